// ===== hw/rtl/ttb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent basis block
// Holds the front-to-back queue entry type and the fixed field widths.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int TEX_W = 16;

  // work handed from the front to the back: edge deltas, uv deltas
  typedef struct packed {
    logic signed [49:0] e1x;
    logic signed [49:0] e1y;
    logic signed [49:0] e1z;
    logic signed [49:0] e2x;
    logic signed [49:0] e2y;
    logic signed [49:0] e2z;
    logic signed [16:0] d1u;
    logic signed [16:0] d1v;
    logic signed [16:0] d2u;
    logic signed [16:0] d2v;
  } ttb_job_t;

endpackage

// ===== hw/rtl/triangle_tangent_basis.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle unit tangent and bitangent
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | pos_x/y/z, tex_u/v, starts_triangle
//  out_    | output    | out_valid/stall  | tangent/bitangent x/y/z, degenerate
//
// Vertices are taken whenever the input does not stall; every third queues a
// job. The vector unit works on one triangle at a time with a bit-serial
// square root and a restoring divider for each component, both run for each
// of the two vectors; a zero determinant goes straight to the output.
// Reset (synchronous, rst_n low) clears the vertex count and held vertices.
// The input stalls only when a third vertex finds the job queue full.
// ----------------------------------------------------------------------------
module triangle_tangent_basis import ttb_pkg::*; #(
  parameter int POS_WIDTH     = 32,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [POS_WIDTH-1:0]     in_pos_x,
  input  logic signed [POS_WIDTH-1:0]     in_pos_y,
  input  logic signed [POS_WIDTH-1:0]     in_pos_z,
  input  logic signed [TEX_W-1:0]         in_tex_u,
  input  logic signed [TEX_W-1:0]         in_tex_v,
  input  logic                            in_starts_triangle,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_z,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_z,
  output logic                            out_degenerate
);

  ttb_job_t fj, qj;
  logic fv, fs, qv, qs;

  ttb_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_tex_u, .in_tex_v, .in_starts_triangle,
    .job_valid(fv), .job_stall(fs), .job(fj)
  );

  ttb_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_stall(fs), .wr_data(fj),
    .rd_valid(qv), .rd_stall(qs), .rd_data(qj)
  );

  ttb_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk, .rst_n, .job_valid(qv), .job_stall(qs), .job(qj),
    .out_valid, .out_stall, .out_tangent_x, .out_tangent_y, .out_tangent_z,
    .out_bitangent_x, .out_bitangent_y, .out_bitangent_z, .out_degenerate
  );

endmodule

// ===== hw/rtl/ttb_front.sv =====
// ----------------------------------------------------------------------------
// ttb_front: vertex collector
// Holds the first two vertices of a triangle and, on the third, pushes the
// edge and uv deltas into the job queue.
// ----------------------------------------------------------------------------
module ttb_front import ttb_pkg::*; #(
  parameter int POS_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_WIDTH-1:0] in_pos_x,
  input  logic signed [POS_WIDTH-1:0] in_pos_y,
  input  logic signed [POS_WIDTH-1:0] in_pos_z,
  input  logic signed [TEX_W-1:0]     in_tex_u,
  input  logic signed [TEX_W-1:0]     in_tex_v,
  input  logic                        in_starts_triangle,
  output logic                        job_valid,
  input  logic                        job_stall,
  output ttb_job_t                    job
);

  logic signed [POS_WIDTH-1:0] p_r [6];
  logic signed [TEX_W-1:0]     t_r [4];
  logic [1:0]                  cnt_r, cnt_nxt, slot;
  logic                        acc;

  assign slot = in_starts_triangle ? 2'd0 : cnt_r;
  // stall only a third vertex that cannot enter the queue
  assign in_stall = job_stall && (slot == 2'd2);
  assign acc = in_valid && !in_stall;
  assign job_valid = in_valid && (slot == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) cnt_nxt = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      for (int i = 0; i < 6; i++) p_r[i] <= '0;
      for (int i = 0; i < 4; i++) t_r[i] <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc && slot == 2'd0) begin
        p_r[0] <= in_pos_x; p_r[1] <= in_pos_y; p_r[2] <= in_pos_z;
        t_r[0] <= in_tex_u; t_r[1] <= in_tex_v;
      end
      if (acc && slot == 2'd1) begin
        p_r[3] <= in_pos_x; p_r[4] <= in_pos_y; p_r[5] <= in_pos_z;
        t_r[2] <= in_tex_u; t_r[3] <= in_tex_v;
      end
    end
  end

  always_comb begin
    job.e1x = 50'(p_r[3]) - 50'(p_r[0]);
    job.e1y = 50'(p_r[4]) - 50'(p_r[1]);
    job.e1z = 50'(p_r[5]) - 50'(p_r[2]);
    job.e2x = 50'(in_pos_x) - 50'(p_r[0]);
    job.e2y = 50'(in_pos_y) - 50'(p_r[1]);
    job.e2z = 50'(in_pos_z) - 50'(p_r[2]);
    job.d1u = 17'(t_r[2]) - 17'(t_r[0]);
    job.d1v = 17'(t_r[3]) - 17'(t_r[1]);
    job.d2u = 17'(in_tex_u) - 17'(t_r[0]);
    job.d2v = 17'(in_tex_v) - 17'(t_r[1]);
  end

endmodule

// ===== hw/rtl/ttb_queue.sv =====
// ----------------------------------------------------------------------------
// ttb_queue: two-entry job queue
// Decouples the vertex collector from the vector unit.
// ----------------------------------------------------------------------------
module ttb_queue import ttb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_stall,
  input  ttb_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_stall,
  output ttb_job_t rd_data
);

  ttb_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

endmodule

// ===== hw/rtl/ttb_back.sv =====
// ----------------------------------------------------------------------------
// ttb_back: tangent and bitangent vector unit
// Sequenced datapath: prescale, cross products with uv deltas, scaling,
// bit-serial square root and a shared restoring divider for each component.
// ----------------------------------------------------------------------------
module ttb_back import ttb_pkg::*; #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_stall,
  input  ttb_job_t                      job,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] out_tangent_z,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_x,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_y,
  output logic signed [OUT_FRAC_BITS+1:0] out_bitangent_z,
  output logic                          out_degenerate
);

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int NW = 31 + OUT_FRAC_BITS;      // numerator width
  localparam logic [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PRE   = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_SCALE = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_SQRT  = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } st_t;

  st_t st_r;
  logic [47:0] em_r [6];       // edge magnitudes after prescale
  logic        es_r [6];       // edge signs
  logic signed [16:0] d1u_r, d1v_r, d2u_r, d2v_r;
  logic signed [63:0] vec_r [3]; // current raw vector
  logic        vs_r [3];
  logic [61:0] m_r [3];
  logic [63:0] sq_r, rem_r, root_r, bit_r;
  logic [1:0]  step_r;          // 0..2 products / components
  logic        which_r;         // 0 tangent, 1 bitangent
  logic        neg_r, degen_r;
  logic [NW-1:0] num_r;
  logic [NW-1:0] q_r;
  logic [5:0]    dc_r;
  logic [OW-1:0] res_r [6];
  logic [OW-1:0] out_r [6];
  logic          degen_out_r;
  logic          ov_r;

  logic signed [63:0] det_w;
  logic [47:0] mx_w;
  logic signed [63:0] p1, p2;
  logic [61:0] mxm;
  logic [31:0] len_w;
  logic [48:0] e_s [6];

  assign job_stall = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_tangent_x = out_r[0];
  assign out_tangent_y = out_r[1];
  assign out_tangent_z = out_r[2];
  assign out_bitangent_x = out_r[3];
  assign out_bitangent_y = out_r[4];
  assign out_bitangent_z = out_r[5];
  assign out_degenerate = degen_out_r;

  always_comb begin
    mx_w = '0;
    for (int i = 0; i < 6; i++) if (em_r[i] > mx_w) mx_w = em_r[i];
    mxm = m_r[0];
    if (m_r[1] > mxm) mxm = m_r[1];
    if (m_r[2] > mxm) mxm = m_r[2];
    len_w = root_r[31:0];
    for (int i = 0; i < 6; i++) e_s[i] = es_r[i] ? -{1'b0, em_r[i]} : {1'b0, em_r[i]};
  end

  // one product pair per cycle (each about 47 x 17)
  always_comb begin
    int a, b;
    a = int'(step_r);
    b = a + 3;
    if (!which_r) begin
      p1 = 64'(signed'(e_s[a])) * 64'(d2v_r);
      p2 = 64'(signed'(e_s[b])) * 64'(d1v_r);
    end else begin
      p1 = 64'(signed'(e_s[b])) * 64'(d1u_r);
      p2 = 64'(signed'(e_s[a])) * 64'(d2u_r);
    end
    det_w = 64'(d1u_r * d2v_r) - 64'(d1v_r * d2u_r);
  end

  function automatic logic [61:0] mag62(input logic signed [63:0] v);
    logic [63:0] t;
    t = v[63] ? -v : v;
    return t[61:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (st_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (job_valid) begin
          em_r[0] <= 48'(job.e1x[49] ? -job.e1x : job.e1x); es_r[0] <= job.e1x[49];
          em_r[1] <= 48'(job.e1y[49] ? -job.e1y : job.e1y); es_r[1] <= job.e1y[49];
          em_r[2] <= 48'(job.e1z[49] ? -job.e1z : job.e1z); es_r[2] <= job.e1z[49];
          em_r[3] <= 48'(job.e2x[49] ? -job.e2x : job.e2x); es_r[3] <= job.e2x[49];
          em_r[4] <= 48'(job.e2y[49] ? -job.e2y : job.e2y); es_r[4] <= job.e2y[49];
          em_r[5] <= 48'(job.e2z[49] ? -job.e2z : job.e2z); es_r[5] <= job.e2z[49];
          d1u_r <= job.d1u; d1v_r <= job.d1v; d2u_r <= job.d2u; d2v_r <= job.d2v;
          which_r <= 1'b0;
          st_r <= S_PRE;
        end
        S_PRE: begin
          // shift until the largest edge magnitude is below 2^45
          if (|mx_w[47:45]) begin
            for (int i = 0; i < 6; i++) em_r[i] <= em_r[i] >> 1;
          end else begin
            neg_r <= det_w[63];
            degen_r <= (det_w == 64'sd0);
            step_r <= 2'd0;
            st_r <= (det_w == 64'sd0) ? S_OUT : S_MUL;
          end
        end
        S_MUL: begin
          vec_r[step_r] <= neg_r ? (p2 - p1) : (p1 - p2);
          if (step_r == 2'd2) st_r <= S_SUM;
          step_r <= (step_r == 2'd2) ? 2'd0 : step_r + 2'd1;
        end
        S_SUM: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= mag62(vec_r[i]);
            vs_r[i] <= vec_r[i][63];
          end
          st_r <= S_SCALE;
        end
        S_SCALE: begin
          if (mxm == '0) begin
            degen_r <= 1'b1;
            st_r <= S_OUT;
          end else if (mxm >= 62'(1) << 30) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (mxm < 62'(1) << 29) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            step_r <= 2'd0;
            sq_r <= '0;
            st_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_r + 64'(m_r[step_r][29:0] * m_r[step_r][29:0]);
          if (step_r == 2'd2) begin
            step_r <= 2'd0;
            root_r <= '0;
            bit_r <= 64'(1) << 62;
            st_r <= S_SQRT;
          end else step_r <= step_r + 2'd1;
        end
        S_SQRT: begin
          // one result bit per cycle
          if (bit_r == '0) begin
            num_r <= (NW'(m_r[0][29:0]) << OUT_FRAC_BITS) + NW'(root_r[31:1]);
            dc_r <= '0;
            q_r <= '0;
            rem_r <= '0;
            st_r <= S_DIV;
          end else begin
            if (sq_r >= root_r + bit_r) begin
              sq_r <= sq_r - (root_r + bit_r);
              root_r <= (root_r >> 1) + bit_r;
            end else root_r <= root_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (dc_r == 6'(NW)) begin
            if (which_r) res_r[3 + step_r] <= vs_r[step_r]
              ? -((q_r > NW'(ONE)) ? ONE : OW'(q_r))
              :  ((q_r > NW'(ONE)) ? ONE : OW'(q_r));
            else res_r[step_r] <= vs_r[step_r]
              ? -((q_r > NW'(ONE)) ? ONE : OW'(q_r))
              :  ((q_r > NW'(ONE)) ? ONE : OW'(q_r));
            if (step_r == 2'd2) begin
              step_r <= 2'd0;
              if (which_r) st_r <= S_OUT;
              else begin
                which_r <= 1'b1;
                st_r <= S_MUL;
              end
            end else begin
              step_r <= step_r + 2'd1;
              num_r <= (NW'(m_r[step_r + 2'd1][29:0]) << OUT_FRAC_BITS)
                       + NW'(root_r[31:1]);
              dc_r <= '0;
              q_r <= '0;
              rem_r <= '0;
            end
          end else begin
            if ({rem_r[62:0], num_r[NW-1]} >= {32'd0, len_w}) begin
              rem_r <= {rem_r[62:0], num_r[NW-1]} - {32'd0, len_w};
              q_r <= {q_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[62:0], num_r[NW-1]};
              q_r <= {q_r[NW-2:0], 1'b0};
            end
            num_r <= num_r << 1;
            dc_r <= dc_r + 6'd1;
          end
        end
        S_OUT: if (!ov_r || !out_stall) begin
          // hold the result in its own register so the next job can start
          for (int i = 0; i < 6; i++) out_r[i] <= degen_r ? '0 : res_r[i];
          degen_out_r <= degen_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tangent basis unit testbench
// Feeds triangle vertices through the in_ channel, predicts the unit tangent,
// unit bitangent and degenerate flag of every completed triangle, and checks
// each out_ transaction in order. A short table of directed vertices comes
// first, then hand-constrained random triangles and stray vertices, with idling.
// ----------------------------------------------------------------------------
module testbench;
  import ttb_pkg::*;

  localparam int PW = 32;
  localparam int OFB = 14;
  localparam int OW = OFB + 2;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int NUM_RANDOM = 1640;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic signed [OW-1:0] tan [3];
    logic signed [OW-1:0] bit3 [3];
    logic degen;
  } basis_t;

  typedef struct {
    logic signed [PW-1:0] px, py, pz;
    logic signed [15:0]   tu, tv;
    logic                 first;
    logic                 has_exp;  // expected result typed in
    logic                 exp_degen;
  } vertex_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [PW-1:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [15:0] in_tex_u = 0, in_tex_v = 0;
  logic in_starts_triangle = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [OW-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [OW-1:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic out_degenerate;

  triangle_tangent_basis #(.POS_WIDTH(PW), .OUT_FRAC_BITS(OFB)) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  longint held_pos [6];
  longint held_uv [4];
  int vtx_idx;

  basis_t expected_bases [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  bit hold_armed = 0;
  bit hold_used = 0;
  bit timed_out = 0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale to [2^29, 2^30), then divide each magnitude by the length
  function automatic bit unit_vector(input longint v [3],
                                     output logic signed [OW-1:0] o [3]);
    longint unsigned m [3];
    longint unsigned mx, sq, len, q, one;
    mx = 0;
    sq = 0;
    one = 64'd1 << OFB;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    for (int i = 0; i < 3; i++) o[i] = '0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sq += m[i] * m[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << OFB) + (len >> 1)) / len;
      if (q > one) q = one;
      o[i] = OW'(v[i] < 0 ? -longint'(q) : longint'(q));
    end
    return 1;
  endfunction

  // advance the vertex counter; return 1 with the basis on a third vertex
  function automatic bit predict_basis(input logic signed [PW-1:0] px, py, pz,
                                       input logic signed [15:0] tu, tv,
                                       input logic first, output basis_t res);
    longint p [3];
    longint e [6];
    longint t [3], b [3];
    longint unsigned em [6];
    longint unsigned mx;
    longint d1u, d1v, d2u, d2v, det;
    bit degen;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    mx = 0;
    if (first || vtx_idx > 2) vtx_idx = 0;
    if (vtx_idx < 2) begin
      for (int i = 0; i < 3; i++) held_pos[vtx_idx * 3 + i] = p[i];
      held_uv[vtx_idx * 2] = tu;
      held_uv[vtx_idx * 2 + 1] = tv;
      vtx_idx++;
      return 0;
    end
    vtx_idx = 0;
    for (int i = 0; i < 3; i++) begin
      e[i] = held_pos[3 + i] - held_pos[i];
      e[3 + i] = p[i] - held_pos[i];
    end
    for (int i = 0; i < 6; i++) begin
      em[i] = mag(e[i]);
      if (em[i] > mx) mx = em[i];
    end
    while (mx >= (64'd1 << 45)) begin
      mx >>= 1;
      for (int i = 0; i < 6; i++) em[i] >>= 1;
    end
    for (int i = 0; i < 6; i++) e[i] = e[i] < 0 ? -longint'(em[i]) : longint'(em[i]);
    d1u = held_uv[2] - held_uv[0];
    d1v = held_uv[3] - held_uv[1];
    d2u = longint'(tu) - held_uv[0];
    d2v = longint'(tv) - held_uv[1];
    det = d1u * d2v - d1v * d2u;
    for (int i = 0; i < 3; i++) begin
      t[i] = e[i] * d2v - e[3 + i] * d1v;
      b[i] = e[3 + i] * d1u - e[i] * d2u;
      if (det < 0) begin
        t[i] = -t[i];
        b[i] = -b[i];
      end
    end
    degen = (det == 0);
    if (!degen && !unit_vector(t, res.tan)) degen = 1;
    if (!degen && !unit_vector(b, res.bit3)) degen = 1;
    if (degen) begin
      for (int i = 0; i < 3; i++) begin
        res.tan[i] = 0;
        res.bit3[i] = 0;
      end
    end
    res.degen = degen;
    return 1;
  endfunction

  // stimulus driver: one transaction per call, holds payload while stalled
  task automatic send_vertex(input logic signed [PW-1:0] px, py, pz,
                             input logic signed [15:0] tu, tv, input logic first);
    basis_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    in_tex_u <= tu;
    in_tex_v <= tv;
    in_starts_triangle <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_basis(px, py, pz, tu, tv, first, r))
      expected_bases.insert(expected_bases.size(), r);
  endtask

  // a well-formed random triangle with random sizes
  task automatic send_triangle();
    int sh;
    logic signed [PW-1:0] base [3];
    logic signed [15:0] bu, bv;
    sh = $urandom_range(3) == 0 ? 31 : $urandom_range(24, 4);
    for (int i = 0; i < 3; i++) base[i] = $urandom;
    bu = 16'($urandom);
    bv = 16'($urandom);
    for (int k = 0; k < 3; k++) begin
      logic signed [PW-1:0] q [3];
      logic signed [15:0] u, v;
      for (int i = 0; i < 3; i++)
        q[i] = k == 0 ? base[i] : base[i] + ($signed($urandom) >>> (31 - sh));
      u = k == 0 || $urandom_range(9) == 0 ? bu : bu + ($signed(16'($urandom)) >>> $urandom_range(15));
      v = k == 0 || $urandom_range(9) == 0 ? bv : bv + ($signed(16'($urandom)) >>> $urandom_range(15));
      send_vertex(q[0], q[1], q[2], u, v, k == 0 ? ($urandom_range(3) != 0) : 1'b0);
    end
  endtask

  localparam logic signed [PW-1:0] PMAX = 32'sh7fffffff;
  localparam logic signed [PW-1:0] PMIN = 32'sh80000000;
  localparam logic signed [PW-1:0] ONE = 32'sh00010000;
  localparam logic signed [15:0] UMAX = 16'sh7fff;
  localparam logic signed [15:0] UMIN = 16'sh8000;
  localparam logic signed [15:0] U1 = 16'sh1000;

  vertex_row_t directed_rows [] = '{
    // all zero right after reset: zero determinant
    '{0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 1, 1},
    // unit axis triangle
    '{0, 0, 0, 0, 0, 1, 0, 0}, '{ONE, 0, 0, U1, 0, 0, 0, 0},
    '{0, ONE, 0, 0, U1, 0, 0, 0},
    // extreme positions and coordinates
    '{PMIN, PMIN, PMIN, UMIN, UMIN, 1, 0, 0}, '{PMAX, PMAX, PMIN, UMAX, UMIN, 0, 0, 0},
    '{PMAX, PMIN, PMAX, UMIN, UMAX, 0, 0, 0},
    // zero edge vectors with valid uv: zero vector
    '{5, 5, 5, 0, 0, 1, 0, 0}, '{5, 5, 5, U1, 0, 0, 0, 0},
    '{5, 5, 5, 0, U1, 0, 1, 1},
    // restart on a would-be third vertex
    '{1, 2, 3, 0, 0, 1, 0, 0}, '{4, 5, 6, U1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 1, 0, 0}, '{-ONE, 0, 0, 0, U1, 0, 0, 0},
    '{0, 0, ONE, U1, 0, 0, 0, 0},
    // negative determinant
    '{0, 0, 0, 0, 0, 1, 0, 0}, '{ONE, 0, 0, 0, U1, 0, 0, 0},
    '{0, ONE, 0, U1, 0, 0, 0, 0},
    // count wraps without the restart flag
    '{ONE, 0, 0, 0, 0, 0, 0, 0}, '{0, ONE, 0, U1, U1, 0, 0, 0},
    '{0, 0, ONE, UMIN, U1, 0, 0, 0}
  };

  initial begin
    basis_t r;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed_rows[n]) begin
      vertex_row_t d;
      d = directed_rows[n];
      send_vertex(d.px, d.py, d.pz, d.tu, d.tv, d.first);
      if (d.has_exp && expected_bases.size() > 0) begin
        r = expected_bases[$];
        if (r.degen !== d.exp_degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: predicted degenerate %0b, table %0b",
                     n, r.degen, d.exp_degen);
        end
      end
    end
    // pause until the pipeline has drained
    in_valid <= 0;
    while (expected_bases.size() > 0) @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 33 : ph == 1 ? 61 : 0;
      recv_idle_pct = ph == 0 ? 61 : ph == 1 ? 33 : 0;
      if (ph == 2) hold_armed = 1;
      for (int n = 0; n < NUM_RANDOM / 9; n++) begin
        if ($urandom_range(9) == 0)
          send_vertex($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      1'($urandom));
        else
          send_triangle();
      end
    end
    in_valid <= 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (expected_bases.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && !timed_out)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_used <= 1;
      hold_off <= HOLD_CYCLES;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
    end
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      basis_t got, want;
      got.tan[0] = out_tangent_x;
      got.tan[1] = out_tangent_y;
      got.tan[2] = out_tangent_z;
      got.bit3[0] = out_bitangent_x;
      got.bit3[1] = out_bitangent_y;
      got.bit3[2] = out_bitangent_z;
      got.degen = out_degenerate;
      if (expected_bases.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        want = expected_bases.pop_front();
        if (got.tan != want.tan || got.bit3 != want.bit3 || got.degen !== want.degen) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp T %0d %0d %0d B %0d %0d %0d D %0b, got T %0d %0d %0d B %0d %0d %0d D %0b",
                     want.tan[0], want.tan[1], want.tan[2], want.bit3[0], want.bit3[1],
                     want.bit3[2], want.degen, got.tan[0], got.tan[1], got.tan[2],
                     got.bit3[0], got.bit3[1], got.bit3[2], got.degen);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
